@@ hdl/bsst_pkg.sv @@
package bsst_pkg;

  localparam int DATA_W          = 32;
  localparam int COUNT_W         = 9;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int ADDR_W          = 3;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 9'd256;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] gap;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

endpackage

@@ hdl/bsst_cell.sv @@
module bsst_cell import bsst_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] slot,
  input  tok_t          tok_in,
  output tok_t          tok_out
);

  logic [DATA_W-1:0] stored;
  logic              occupied;
  logic              is_slot;
  logic              less;
  logic [DATA_W-1:0] gap;
  tok_t              tok_next;

  assign occupied = CW'(INDEX) < slot;
  assign is_slot  = CW'(INDEX) == slot;
  assign less     = $signed(tok_in.value) < $signed(stored);
  assign gap      = less ? (stored - tok_in.value) : (tok_in.value - stored);

  always_comb begin
    tok_next = tok_in;
    if (occupied && (gap < tok_in.gap)) begin
      tok_next.gap = gap;
    end
  end

  // the passing value lands in the first free cell
  always_ff @(posedge clk) begin
    if (tok_in.valid && is_slot) begin
      stored <= tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.value <= tok_next.value;
    tok_out.gap   <= tok_next.gap;
  end

endmodule

@@ hdl/bounded_set_span_tracker.sv @@
// channel   direction  handshake            payload
// in        in         in_valid/in_ready    value
// out       out        out_valid/out_ready  status, count, spans_valid, shortest_span,
//                                           longest_span
// cfg       in         apb write/read       paddr, pwdata, prdata (capacity at 0)
//
// a rejected transaction goes from accept to the finish state, then into the output register
// a stored value walks the cell chain one cell a cycle, then the finish state and output register
// the next transaction is accepted once the result is in the output register
// out_ready low holds the result and, once the next one is done, the input
// synchronous active-high reset: empty set, capacity 256, no clearing pass
module bounded_set_span_tracker import bsst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [COUNT_W-1:0] count,
  output logic               spans_valid,
  output logic [DATA_W-1:0]  shortest_span,
  output logic [DATA_W-1:0]  longest_span,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  state_t state, state_next;

  logic [COUNT_W-1:0] capacity;
  logic [CW-1:0]      held_count;
  logic [CW-1:0]      slot;
  logic [DATA_W-1:0]  smallest;
  logic [DATA_W-1:0]  largest;
  logic [DATA_W-1:0]  min_gap;
  logic               res_status;
  tok_t               inj;
  tok_t               tok [MAX_ENTRIES+1];

  logic               accept;
  logic               full;
  logic               load_out;
  logic               two_held;
  logic [CW+COUNT_W-1:0] count_wide;

  assign accept = in_valid && in_ready;
  assign full   = (LW'(held_count) >= LW'(capacity)) || (LW'(held_count) >= LW'(MAX_ENTRIES));

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[COUNT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = full ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (tok[MAX_ENTRIES].valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE:   in_ready = !rst;
      ST_RUN:    in_ready = 1'b0;
      ST_FINISH: load_out = !out_valid || out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      smallest   <= '0;
      largest    <= '0;
      min_gap    <= '1;
    end else begin
      if (accept && !full) begin
        held_count <= held_count + CW'(1);
        if (held_count == '0) begin
          smallest <= value;
          largest  <= value;
        end else begin
          if ($signed(value) < $signed(smallest)) begin
            smallest <= value;
          end
          if ($signed(largest) < $signed(value)) begin
            largest <= value;
          end
        end
      end
      if (tok[MAX_ENTRIES].valid) begin
        min_gap <= tok[MAX_ENTRIES].gap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inj.valid <= 1'b0;
    end else begin
      inj.valid <= accept && !full;
    end
    if (accept) begin
      res_status <= full;
      slot       <= held_count;
      inj.value  <= value;
      inj.gap    <= min_gap;
    end
  end

  // cell chain
  assign tok[0] = inj;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    bsst_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .slot    (slot),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // output register
  assign two_held   = held_count >= CW'(2);
  assign count_wide = {{COUNT_W{1'b0}}, held_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res_status;
      count         <= count_wide[COUNT_W-1:0];
      spans_valid   <= two_held;
      shortest_span <= two_held ? min_gap : '0;
      longest_span  <= two_held ? (largest - smallest) : '0;
    end
  end

`ifndef SYNTHESIS
  a_exit_only_running: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_ENTRIES].valid |-> state == ST_RUN)
    else $error("token left the chain outside a run");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !full |=> held_count == $past(held_count) + CW'(1))
    else $error("held count did not step on a stored value");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(held_count) <= LW'(MAX_ENTRIES))
    else $error("held count beyond the cell chain");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result loaded outside finish");
`endif

endmodule
